// ===== hdl/assert_macros.svh =====
// shared assertion shorthands, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RXC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RXC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rxc_pkg.sv =====
package rxc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CHAN_W    = 8;
  localparam int CHROMA_W  = 16;
  localparam int BRIGHT_W  = 8;
  localparam int LIN_W     = FRAC_BITS + 1;
  localparam int COEF_W    = 17;
  localparam int PROD_W    = LIN_W + COEF_W;
  localparam int XYZ_W     = PROD_W + 2;
  localparam int SUM_W     = XYZ_W + 2;
  localparam int REM_W     = SUM_W + 1;
  localparam int DIV_LAT   = CHROMA_W + 1;
  localparam int UNIT_SH   = FRAC_BITS + 16;
  localparam int YCL_W     = UNIT_SH + 1;
  localparam int LUT_DEPTH = 1 << CHAN_W;
  localparam int BRIGHT_SCALE = 254;

  // exact-root search needs room for t^12 * 2^(5*frac)
  localparam int BIG_W        = 320;
  localparam int GAMMA_DEN    = 10761;
  localparam int GAMMA_STEP   = 40;
  localparam int GAMMA_OFS    = 561;
  localparam int LINEAR_TOP   = 10;
  localparam int LINEAR_NUM   = 5;
  localparam int LINEAR_DEN   = 16473;

  typedef logic [CHAN_W-1:0]   chan_t;
  typedef logic [CHROMA_W-1:0] chroma_t;
  typedef logic [BRIGHT_W-1:0] bright_t;
  typedef logic [LIN_W-1:0]    lin_t;
  typedef logic [COEF_W-1:0]   coef_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [XYZ_W-1:0]    xyz_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [LUT_DEPTH-1:0][LIN_W-1:0] lin_lut_t;

  // wide-gamut d65 matrix, q1.16; row 0..2 = x,y,z, col 0..2 = r,g,b
  function automatic coef_t coef(int unsigned row, int unsigned col);
    coef_t val;
    case (row * 3 + col)
      0:       val = COEF_W'(42594);
      1:       val = COEF_W'(6780);
      2:       val = COEF_W'(12918);
      3:       val = COEF_W'(15357);
      4:       val = COEF_W'(48698);
      5:       val = COEF_W'(1481);
      6:       val = COEF_W'(0);
      7:       val = COEF_W'(3478);
      8:       val = COEF_W'(67880);
      default: val = '0;
    endcase
    return val;
  endfunction

  // srgb decode of one code: linear segment, else largest l with l^5 <= t^12 * one^5
  function automatic lin_t lin_entry(int unsigned code);
    logic [BIG_W-1:0] d12;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] low_val;
    logic [LIN_W:0]   lo;
    logic [LIN_W:0]   hi;
    logic [LIN_W:0]   mid;
    lin_t             res;
    d12 = BIG_W'(1);
    for (int k = 0; k < 12; k++) d12 = d12 * BIG_W'(GAMMA_DEN);
    if (code <= LINEAR_TOP) begin
      low_val = (BIG_W'(code * LINEAR_NUM) << FRAC_BITS) / LINEAR_DEN;
      res = LIN_W'(low_val);
    end else begin
      rhs = BIG_W'(1);
      for (int k = 0; k < 12; k++) rhs = rhs * BIG_W'(GAMMA_STEP * code + GAMMA_OFS);
      for (int k = 0; k < 5; k++) rhs = rhs << FRAC_BITS;
      lo = '0;
      hi = (LIN_W + 1)'(1) << FRAC_BITS;
      for (int it = 0; it < LIN_W + 2; it++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo + (LIN_W + 1)'(1)) >> 1);
          lhs = d12;
          for (int k = 0; k < 5; k++) lhs = lhs * BIG_W'(mid);
          if (lhs <= rhs) lo = mid;
          else hi = mid - (LIN_W + 1)'(1);
        end
      end
      res = LIN_W'(lo);
    end
    return res;
  endfunction

  function automatic lin_lut_t build_lin_lut();
    lin_lut_t lut;
    for (int c = 0; c < LUT_DEPTH; c++) lut[c] = lin_entry(c);
    return lut;
  endfunction

  localparam lin_lut_t LIN_LUT = build_lin_lut();

endpackage

// ===== hdl/rxc_if.sv =====
interface rxc_pix_if;
  logic          valid;
  logic          ready;
  rxc_pkg::chan_t red;
  rxc_pkg::chan_t green;
  rxc_pkg::chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rxc_res_if;
  logic              valid;
  logic              ready;
  rxc_pkg::chroma_t  chroma_x;
  rxc_pkg::chroma_t  chroma_y;
  rxc_pkg::bright_t  brightness;

  modport source (output valid, output chroma_x, output chroma_y, output brightness,
                  input ready);
  modport sink   (input valid, input chroma_x, input chroma_y, input brightness,
                  output ready);
endinterface

// ===== hdl/rgb_to_cie_xy_converter.sv =====
// a request runs through the decode, product, sum, operand, divider and output registers
// throughput: one pixel per unstalled cycle, set by the bit-per-stage chroma dividers
// a stalled output freezes the whole pipeline in place; no request is lost or repeated
// reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset
module rgb_to_cie_xy_converter (
  input  logic         clk,
  input  logic         rst_n,
  rxc_pix_if.sink      in_pix,
  rxc_res_if.source    out_res
);

  `include "assert_macros.svh"

  // valid line: decode, multiply, sum, total/brightness, then the divider stages
  localparam int PIPE_LEN = 4 + rxc_pkg::DIV_LAT;
  localparam logic [rxc_pkg::XYZ_W-1:0] UNIT_XYZ =
    rxc_pkg::XYZ_W'(1) << rxc_pkg::UNIT_SH;
  localparam logic [rxc_pkg::BRIGHT_W-1:0] BRIGHT_MAX =
    rxc_pkg::BRIGHT_W'(rxc_pkg::BRIGHT_SCALE);
  localparam logic [rxc_pkg::CHROMA_W:0] ONE_Q16 =
    (rxc_pkg::CHROMA_W + 1)'(1) << rxc_pkg::CHROMA_W;

  logic                  pipe_en;
  logic [PIPE_LEN-1:0]   pipe_v_r;
  logic [PIPE_LEN-1:0]   pipe_v_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;

  // pipeline payload
  rxc_pkg::lin_t         lin_r  [3];
  rxc_pkg::prod_t        prod_r [3][3];
  rxc_pkg::xyz_t         xyz_r  [3];
  rxc_pkg::sum_t         sum_r;
  rxc_pkg::sum_t         num_x_r;
  rxc_pkg::sum_t         num_y_r;
  rxc_pkg::bright_t      bright_r;
  rxc_pkg::bright_t      bd_r   [rxc_pkg::DIV_LAT];

  logic [rxc_pkg::YCL_W-1:0]                    y_clamp;
  logic [rxc_pkg::YCL_W+rxc_pkg::BRIGHT_W-1:0]  y_scaled;
  rxc_pkg::chroma_t      quo_x;
  rxc_pkg::chroma_t      quo_y;

  rxc_pkg::chroma_t      out_x_r;
  rxc_pkg::chroma_t      out_y_r;
  rxc_pkg::bright_t      out_bright_r;
  logic [rxc_pkg::CHROMA_W:0] chroma_sum;

  // whole pipe advances unless a finished result is waiting on the sink
  assign pipe_en      = !out_valid_r || out_res.ready;
  assign in_pix.ready = pipe_en;

  assign pipe_v_nxt    = {pipe_v_r[PIPE_LEN-2:0], in_pix.valid};
  assign out_valid_nxt = pipe_v_r[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      pipe_v_r    <= pipe_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stage 1: gamma decode through the constant table
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      lin_r[0] <= rxc_pkg::LIN_LUT[in_pix.red];
      lin_r[1] <= rxc_pkg::LIN_LUT[in_pix.green];
      lin_r[2] <= rxc_pkg::LIN_LUT[in_pix.blue];
    end
  end

  // stage 2: nine constant-coefficient products
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          prod_r[r][c] <= rxc_pkg::PROD_W'(lin_r[c]) *
                          rxc_pkg::PROD_W'(rxc_pkg::coef(r, c));
        end
      end
    end

    // stage 3: row sums give x, y, z
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        xyz_r[r] <= rxc_pkg::XYZ_W'(prod_r[r][0]) + rxc_pkg::XYZ_W'(prod_r[r][1]) +
                    rxc_pkg::XYZ_W'(prod_r[r][2]);
      end
    end
  end

  // stage 4: divider operands and brightness from y clamped to one
  assign y_clamp  = (xyz_r[1] > UNIT_XYZ) ? rxc_pkg::YCL_W'(UNIT_XYZ)
                                          : rxc_pkg::YCL_W'(xyz_r[1]);
  assign y_scaled = (rxc_pkg::YCL_W + rxc_pkg::BRIGHT_W)'(y_clamp) *
                    (rxc_pkg::YCL_W + rxc_pkg::BRIGHT_W)'(rxc_pkg::BRIGHT_SCALE);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sum_r    <= rxc_pkg::SUM_W'(xyz_r[0]) + rxc_pkg::SUM_W'(xyz_r[1]) +
                  rxc_pkg::SUM_W'(xyz_r[2]);
      num_x_r  <= rxc_pkg::SUM_W'(xyz_r[0]);
      num_y_r  <= rxc_pkg::SUM_W'(xyz_r[1]);
      bright_r <= y_scaled[rxc_pkg::UNIT_SH +: rxc_pkg::BRIGHT_W];
    end
  end

  // stages 5..21: two bit-per-stage dividers, brightness rides alongside
  rxc_div u_div_x (
    .clk (clk),
    .en  (pipe_en),
    .num (num_x_r),
    .den (sum_r),
    .quo (quo_x)
  );

  rxc_div u_div_y (
    .clk (clk),
    .en  (pipe_en),
    .num (num_y_r),
    .den (sum_r),
    .quo (quo_y)
  );

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      bd_r[0] <= bright_r;
      for (int i = 1; i < rxc_pkg::DIV_LAT; i++) bd_r[i] <= bd_r[i-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_x_r      <= quo_x;
      out_y_r      <= quo_y;
      out_bright_r <= bd_r[rxc_pkg::DIV_LAT-1];
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.chroma_x   = out_x_r;
  assign out_res.chroma_y   = out_y_r;
  assign out_res.brightness = out_bright_r;

  assign chroma_sum = {1'b0, out_x_r} + {1'b0, out_y_r};

  `RXC_ASSERT_NXT(a_req_enters, in_pix.valid && in_pix.ready, pipe_v_r[0],
                  "accepted request missing from pipeline")
  `RXC_ASSERT_NXT(a_stall_holds, out_valid_r && !out_res.ready,
                  $stable(pipe_v_r) && $stable(out_x_r) && $stable(out_bright_r),
                  "pipeline moved during output stall")
  `RXC_ASSERT_IMP(a_bright_range, out_valid_r, out_bright_r <= BRIGHT_MAX,
                  "brightness above full scale")
  `RXC_ASSERT_IMP(a_chroma_sum, out_valid_r, chroma_sum <= ONE_Q16,
                  "chroma x plus y above one")

endmodule

// ===== hdl/rxc_div.sv =====
// pipelined restoring divider, one quotient bit per stage: floor(num * 2^16 / den)
module rxc_div (
  input  logic             clk,
  input  logic             en,
  input  rxc_pkg::sum_t    num,
  input  rxc_pkg::sum_t    den,
  output rxc_pkg::chroma_t quo
);

  localparam int STEPS = rxc_pkg::CHROMA_W;
  localparam int RW    = rxc_pkg::REM_W;
  localparam int CW    = rxc_pkg::CHROMA_W;

  logic [RW-1:0]    rem_r  [STEPS+1];
  rxc_pkg::sum_t    den_r  [STEPS+1];
  rxc_pkg::chroma_t quo_r  [STEPS+1];
  logic             sat_r  [STEPS+1];
  logic             zero_r [STEPS+1];

  // num <= den; equal means a quotient of one, which saturates; den 0 gives 0
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= (num == den) ? '0 : {1'b0, num};
      den_r[0]  <= den;
      quo_r[0]  <= '0;
      sat_r[0]  <= (num == den) && (den != '0);
      zero_r[0] <= (den == '0);
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [RW-1:0] dbl;
    logic [RW:0]   diff;
    logic          take;

    assign dbl  = {rem_r[i][RW-2:0], 1'b0};
    assign diff = {1'b0, dbl} - {2'b00, den_r[i]};
    assign take = !diff[RW];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= take ? diff[RW-1:0] : dbl;
        den_r[i+1]  <= den_r[i];
        quo_r[i+1]  <= {quo_r[i][CW-2:0], take};
        sat_r[i+1]  <= sat_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  assign quo = zero_r[STEPS] ? '0 : (sat_r[STEPS] ? '1 : quo_r[STEPS]);

endmodule
